>>> src/segment_convex_hull_clip_macros.svh
// Assertion macros shared by the hull clip RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef SEGMENT_CONVEX_HULL_CLIP_MACROS_SVH
`define SEGMENT_CONVEX_HULL_CLIP_MACROS_SVH

// Check a property at every clock edge outside reset.
`define SEGHC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define SEGHC_NEVER(lbl, cond, msg) \
    `SEGHC_ASSERT(lbl, !(cond), msg)

`endif

>>> src/seghc_pkg.sv
// Shared constants and types for the segment convex hull clip block.
// No dependencies.
`default_nettype none
package seghc_pkg;
    localparam int MAX_SIDES = 16;
    localparam int SLOT_W    = $clog2(MAX_SIDES);
    localparam int CNT_W     = $clog2(MAX_SIDES + 1);

    localparam int DIST_W  = 37;
    localparam int NUM_W   = 38;
    localparam int RATIO_W = 18;
    localparam int QUO_STEPS = 18;

    localparam logic signed [RATIO_W-1:0] ONE_Q16   = 18'sd65536;
    localparam logic signed [RATIO_W-1:0] MONE_Q16  = -18'sd65536;
    localparam logic signed [RATIO_W-1:0] RATIO_MAX = 18'sd131071;
    localparam logic signed [RATIO_W-1:0] RATIO_MIN = -18'sd131072;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TRACE = 1'b1;

    localparam logic CFG_SIDE_COUNT = 1'b0;
    localparam logic CFG_EPSILON    = 1'b1;

    localparam logic [16:0] EPS_RESET = 17'd2048;

    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic signed [NUM_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [RATIO_W-1:0] quo;
    } div_rsp_t;
endpackage
`default_nettype wire

>>> src/seghc_div.sv
// Serial signed ratio divider: (num * 65536) / den, truncated, saturated to Q2.16.
// Depends on seghc_pkg.
`default_nettype none
module seghc_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire seghc_pkg::div_req_t req,
    output seghc_pkg::div_rsp_t      rsp
);
    import seghc_pkg::*;

    logic                    busy_reg, done_reg, neg_reg, ovf_reg;
    logic [4:0]              cnt_reg;
    logic [NUM_W:0]          rem_reg;
    logic [NUM_W-1:0]        den_reg;
    logic [QUO_STEPS-1:0]    nsh_reg, quo_reg;
    logic [NUM_W-1:0]        a_abs, d_abs;
    logic [NUM_W:0]          trial;
    logic [RATIO_W-1:0]      mag;

    assign a_abs = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
    assign d_abs = req.den[NUM_W-1] ? NUM_W'(-req.den) : NUM_W'(req.den);
    assign trial = {rem_reg[NUM_W-1:0], nsh_reg[QUO_STEPS-1]};
    assign mag   = ovf_reg ? '1 : quo_reg;

    always_comb
    begin
        rsp.done = done_reg;
        if (neg_reg)
            rsp.quo = (mag > 18'd131072) ? RATIO_MIN : RATIO_W'(-mag);
        else
            rsp.quo = (mag > 18'd131071) ? RATIO_MAX : $signed(mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                neg_reg  <= req.num[NUM_W-1] ^ req.den[NUM_W-1];
                ovf_reg  <= {2'b00, a_abs} >= {d_abs, 2'b00};
                rem_reg  <= (NUM_W+1)'(a_abs[NUM_W-1:2]);
                nsh_reg  <= {a_abs[1:0], 16'd0};
                quo_reg  <= '0;
                den_reg  <= d_abs;
            end
            else if (busy_reg)
            begin
                // one quotient bit per cycle
                if (trial >= {1'b0, den_reg})
                begin
                    rem_reg <= trial - {1'b0, den_reg};
                    quo_reg <= {quo_reg[QUO_STEPS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[QUO_STEPS-2:0], 1'b0};
                end
                nsh_reg <= {nsh_reg[QUO_STEPS-2:0], 1'b0};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(QUO_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> src/segment_convex_hull_clip.sv
// Top level of the segment clip against a convex hull of planes.
// Depends on seghc_pkg, seghc_div and segment_convex_hull_clip_macros.svh.
//
//  channel | signals                               | beat
//  --------+---------------------------------------+---------------------------------
//  in      | in_valid/in_ready + action..end_z     | plane write or segment trace
//  out     | out_valid/out_ready + hit..hit_normal | one result per trace
//  cfg     | cfg_we, cfg_index, cfg_data           | register write, no handshake
//
// A plane write is taken as a single beat. Per plane, a trace does one memory read,
// serial 16x32 products, a distance and a classify step, and the 18-step serial divider,
// which planes the segment does not cross skip; the final point uses three 33x18
// products.
// The walk stops early when both ends lie outside one plane.
// Reset clears control state and reloads the configuration registers; the plane memory is undefined until written.
// A finished result waits in the output register; the block stalls before loading
// the next result only while that register is full and out_ready is low.
`default_nettype none
`include "segment_convex_hull_clip_macros.svh"
module segment_convex_hull_clip (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [16:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        action,
    input  wire logic [3:0]  plane_slot,
    input  wire logic signed [15:0] normal_in_x,
    input  wire logic signed [15:0] normal_in_y,
    input  wire logic signed [15:0] normal_in_z,
    input  wire logic signed [31:0] plane_offset,
    input  wire logic signed [31:0] start_x,
    input  wire logic signed [31:0] start_y,
    input  wire logic signed [31:0] start_z,
    input  wire logic signed [31:0] end_x,
    input  wire logic signed [31:0] end_y,
    input  wire logic signed [31:0] end_z,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             hit,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic signed [31:0] point_z,
    output logic             normal_valid,
    output logic signed [15:0] hit_normal_x,
    output logic signed [15:0] hit_normal_y,
    output logic signed [15:0] hit_normal_z
);
    import seghc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_MUL, S_DIST, S_CLASS, S_DIV, S_FIN, S_PT, S_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [4:0]  side_count_reg;
    logic [16:0] epsilon_reg;

    // plane memory: {nx, ny, nz, offset}
    logic [79:0] mem [MAX_SIDES];
    logic [79:0] rd_reg;

    logic [SLOT_W-1:0] plane_idx_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [2:0]        step_reg;
    logic signed [31:0] s_reg [3];
    logic signed [31:0] e_reg [3];
    logic signed [47:0] prod_reg;
    logic signed [49:0] acc_s_reg, acc_e_reg;
    logic signed [DIST_W-1:0] ds_reg, de_reg;
    logic signed [RATIO_W-1:0] entry_reg, exit_reg;
    logic signed [15:0] hn_reg [3];
    logic               nvalid_reg, entering_reg;
    logic signed [50:0] pprod_reg;
    logic signed [31:0] res_pt_reg [3];
    logic               res_hit_reg;

    // output register
    logic               out_valid_reg, hit_out_reg, nvalid_out_reg;
    logic signed [31:0] pt_out_reg [3];
    logic signed [15:0] hn_out_reg [3];

    logic signed [15:0] rd_nrm [3];
    logic signed [31:0] rd_off;
    logic [1:0]         k;
    logic signed [15:0] mul_n;
    logic signed [31:0] mul_c;
    logic signed [47:0] mul_p;
    logic signed [DIST_W-1:0] ds_calc, de_calc;
    logic signed [32:0] diff;
    logic signed [50:0] pmul;
    logic               last_plane;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    assign rd_nrm[0] = $signed(rd_reg[79:64]);
    assign rd_nrm[1] = $signed(rd_reg[63:48]);
    assign rd_nrm[2] = $signed(rd_reg[47:32]);
    assign rd_off    = $signed(rd_reg[31:0]);

    assign k     = (step_reg < 3'd3) ? step_reg[1:0] : 2'(step_reg - 3'd3);
    assign mul_n = rd_nrm[k];
    assign mul_c = (step_reg < 3'd3) ? s_reg[k] : e_reg[k];
    assign mul_p = mul_n * mul_c;

    // floor shift of the dot product, then add the plane offset
    assign ds_calc = DIST_W'(acc_s_reg >>> 14) + DIST_W'(rd_off);
    assign de_calc = DIST_W'(acc_e_reg >>> 14) + DIST_W'(rd_off);

    assign diff = 33'(e_reg[step_reg[1:0]]) - 33'(s_reg[step_reg[1:0]]);
    assign pmul = diff * entry_reg;

    assign last_plane = (CNT_W'(plane_idx_reg) + CNT_W'(1)) == n_reg;

    always_comb
    begin
        div_req.start = (state_reg == S_CLASS) && ((ds_reg > 0) != (de_reg > 0));
        div_req.den   = NUM_W'(ds_reg) - NUM_W'(de_reg);
        if (ds_reg > de_reg)
            div_req.num = NUM_W'(ds_reg) - NUM_W'(epsilon_reg);
        else
            div_req.num = NUM_W'(ds_reg) + NUM_W'(epsilon_reg);
    end

    seghc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign hit          = hit_out_reg;
    assign point_x      = pt_out_reg[0];
    assign point_y      = pt_out_reg[1];
    assign point_z      = pt_out_reg[2];
    assign normal_valid = nvalid_out_reg;
    assign hit_normal_x = hn_out_reg[0];
    assign hit_normal_y = hn_out_reg[1];
    assign hit_normal_z = hn_out_reg[2];

    // plane memory: write from an accepted plane beat, read the walk index
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && action == ACT_WRITE)
            mem[plane_slot] <= {normal_in_x, normal_in_y, normal_in_z, plane_offset};
        rd_reg <= mem[plane_idx_reg];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_count_reg <= '0;
            epsilon_reg    <= EPS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SIDE_COUNT: side_count_reg <= cfg_data[4:0];
                CFG_EPSILON:    epsilon_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            plane_idx_reg <= '0;
        end
        else
        begin
            // load a new result when the register frees up, else drop the taken beat
            if (state_reg == S_OUT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && action == ACT_TRACE)
                    begin
                        s_reg[0] <= start_x; s_reg[1] <= start_y; s_reg[2] <= start_z;
                        e_reg[0] <= end_x;   e_reg[1] <= end_y;   e_reg[2] <= end_z;
                        entry_reg  <= MONE_Q16;
                        exit_reg   <= ONE_Q16;
                        nvalid_reg <= 1'b0;
                        for (int j = 0; j < 3; j++)
                            hn_reg[j] <= '0;
                        plane_idx_reg <= '0;
                        // clamp the walk length to the table depth
                        n_reg <= (side_count_reg > 5'(MAX_SIDES)) ? CNT_W'(MAX_SIDES)
                                                                  : CNT_W'(side_count_reg);
                        if (side_count_reg == 5'd0)
                            state_reg <= S_FIN;
                        else
                            state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    // memory read in flight; clear the accumulators
                    acc_s_reg <= '0;
                    acc_e_reg <= '0;
                    step_reg  <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if (step_reg < 3'd6)
                        prod_reg <= mul_p;
                    if (step_reg >= 3'd1 && step_reg <= 3'd3)
                        acc_s_reg <= acc_s_reg + 50'(prod_reg);
                    else if (step_reg >= 3'd4)
                        acc_e_reg <= acc_e_reg + 50'(prod_reg);
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd6)
                        state_reg <= S_DIST;
                end
                S_DIST:
                begin
                    ds_reg    <= ds_calc;
                    de_reg    <= de_calc;
                    state_reg <= S_CLASS;
                end
                S_CLASS:
                begin
                    entering_reg <= ds_reg > de_reg;
                    if (ds_reg > 0 && de_reg > 0)
                    begin
                        // both ends outside: give back the end point, no hit
                        res_hit_reg <= 1'b0;
                        for (int j = 0; j < 3; j++)
                            res_pt_reg[j] <= e_reg[j];
                        state_reg <= S_OUT;
                    end
                    else if (ds_reg <= 0 && de_reg <= 0)
                    begin
                        if (last_plane)
                            state_reg <= S_FIN;
                        else
                        begin
                            plane_idx_reg <= plane_idx_reg + SLOT_W'(1);
                            state_reg     <= S_RD;
                        end
                    end
                    else
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        if (entering_reg)
                        begin
                            if (div_rsp.quo > entry_reg)
                            begin
                                entry_reg  <= div_rsp.quo;
                                nvalid_reg <= 1'b1;
                                for (int j = 0; j < 3; j++)
                                    hn_reg[j] <= rd_nrm[j];
                            end
                        end
                        else if (div_rsp.quo < exit_reg)
                            exit_reg <= div_rsp.quo;
                        if (last_plane)
                            state_reg <= S_FIN;
                        else
                        begin
                            plane_idx_reg <= plane_idx_reg + SLOT_W'(1);
                            state_reg     <= S_RD;
                        end
                    end
                end
                S_FIN:
                begin
                    step_reg <= '0;
                    if (entry_reg < exit_reg && entry_reg > MONE_Q16)
                    begin
                        res_hit_reg <= 1'b1;
                        if (entry_reg < 0)
                            entry_reg <= '0;
                        state_reg <= S_PT;
                    end
                    else
                    begin
                        res_hit_reg <= 1'b0;
                        for (int j = 0; j < 3; j++)
                            res_pt_reg[j] <= e_reg[j];
                        state_reg <= S_OUT;
                    end
                end
                S_PT:
                begin
                    // interpolate one axis per cycle, product registered first
                    if (step_reg < 3'd3)
                        pprod_reg <= pmul;
                    if (step_reg >= 3'd1)
                        res_pt_reg[2'(step_reg - 3'd1)] <=
                            s_reg[2'(step_reg - 3'd1)] + 32'(pprod_reg >>> 16);
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd3)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        hit_out_reg    <= res_hit_reg;
                        nvalid_out_reg <= nvalid_reg;
                        for (int j = 0; j < 3; j++)
                        begin
                            pt_out_reg[j] <= res_pt_reg[j];
                            hn_out_reg[j] <= hn_reg[j];
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `SEGHC_ASSERT(a_nrm_zero, out_valid_reg && !nvalid_out_reg |-> hn_out_reg[0] == 0 && hn_out_reg[1] == 0 && hn_out_reg[2] == 0, "normal set without a raising plane")
    `SEGHC_ASSERT(a_div_done_state, div_rsp.done |-> state_reg == S_DIV, "divider finished outside the divide step")
    `SEGHC_ASSERT(a_idx_range, state_reg == S_RD |-> CNT_W'(plane_idx_reg) < n_reg, "plane index beyond walk length")
    `SEGHC_NEVER(a_neg_entry, state_reg == S_PT && step_reg == 3'd1 && entry_reg < 0, "negative ratio at interpolation")

endmodule
`default_nettype wire

>>> tb/tb_segment_convex_hull_clip.sv
// Self-checking bench for segment_convex_hull_clip: plane writes and segment traces.
// Depends on seghc_pkg and the segment_convex_hull_clip RTL.
`default_nettype none
module tb_segment_convex_hull_clip;
    import seghc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic               nvalid;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } clip_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = CFG_SIDE_COUNT;
    logic [16:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic action = ACT_WRITE;
    logic [3:0] plane_slot = '0;
    logic signed [15:0] normal_in_x = '0, normal_in_y = '0, normal_in_z = '0;
    logic signed [31:0] plane_offset = '0;
    logic signed [31:0] start_x = '0, start_y = '0, start_z = '0;
    logic signed [31:0] end_x = '0, end_y = '0, end_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic hit, normal_valid;
    logic signed [31:0] point_x, point_y, point_z;
    logic signed [15:0] hit_normal_x, hit_normal_y, hit_normal_z;

    segment_convex_hull_clip uut (.*);

    always #1 clk = ~clk;

    // Predictor copy of the hull table and registers.
    logic signed [15:0] hull_nx [MAX_SIDES];
    logic signed [15:0] hull_ny [MAX_SIDES];
    logic signed [15:0] hull_nz [MAX_SIDES];
    logic signed [31:0] hull_d  [MAX_SIDES];
    logic [4:0]  sides_now = '0;
    logic [16:0] eps_now = EPS_RESET;

    clip_res_t pending_hits[$];
    int  errors = 0;
    bit  rx_hold = 1'b0;   // long receiver hold-off while set
    bit  rx_stall_mode = 1'b1;

    // Signed distance: exact dot product, floor shift by 14, plus offset.
    function automatic longint plane_distance(int i, longint px, longint py, longint pz);
        longint acc;
        acc = longint'(hull_nx[i]) * px + longint'(hull_ny[i]) * py
            + longint'(hull_nz[i]) * pz;
        return (acc >>> 14) + longint'(hull_d[i]);
    endfunction

    function automatic longint clip_ratio(longint num, longint den);
        longint q;
        if (den == 0) return 0;
        q = (num * 65536) / den;
        if (q > 131071) q = 131071;
        if (q < -131072) q = -131072;
        return q;
    endfunction

    function automatic clip_res_t predict_clip(longint sx, longint sy, longint sz,
                                               longint ex, longint ey, longint ez);
        clip_res_t r;
        longint entry, exitr, ds, de, q;
        int n;
        bit early;
        entry = -65536;
        exitr = 65536;
        early = 1'b0;
        r = '0;
        r.px = ex[31:0]; r.py = ey[31:0]; r.pz = ez[31:0];
        n = (sides_now > MAX_SIDES) ? MAX_SIDES : sides_now;
        for (int i = 0; i < n && !early; i++) begin
            ds = plane_distance(i, sx, sy, sz);
            de = plane_distance(i, ex, ey, ez);
            if (ds > 0 && de > 0) early = 1'b1;
            else if (!(ds <= 0 && de <= 0)) begin
                if (ds > de) begin
                    q = clip_ratio(ds - longint'(eps_now), ds - de);
                    if (q > entry) begin
                        entry = q;
                        r.nx = hull_nx[i]; r.ny = hull_ny[i]; r.nz = hull_nz[i];
                        r.nvalid = 1'b1;
                    end
                end else begin
                    q = clip_ratio(ds + longint'(eps_now), ds - de);
                    if (q < exitr) exitr = q;
                end
            end
        end
        if (!early && entry < exitr && entry > -65536) begin
            if (entry < 0) entry = 0;
            r.px = 32'(sx + (((ex - sx) * entry) >>> 16));
            r.py = 32'(sy + (((ey - sy) * entry) >>> 16));
            r.pz = 32'(sz + (((ez - sz) * entry) >>> 16));
            r.hit = 1'b1;
        end
        return r;
    endfunction

    // Random gap: mostly short, sometimes long.
    task automatic idle_gap();
        int k;
        k = $urandom_range(0, 19);
        if (k < 10) return;
        repeat (k < 18 ? $urandom_range(1, 3) : $urandom_range(20, 80)) @(posedge clk);
    endtask

    // Send one beat and hold it until accepted; update the predictor at acceptance.
    task automatic send_beat(logic act, logic [3:0] slot,
                             logic signed [15:0] nx, ny, nz, logic signed [31:0] d,
                             logic signed [31:0] sx, sy, sz, ex, ey, ez);
        in_valid <= 1'b1;
        action <= act; plane_slot <= slot;
        normal_in_x <= nx; normal_in_y <= ny; normal_in_z <= nz; plane_offset <= d;
        start_x <= sx; start_y <= sy; start_z <= sz;
        end_x <= ex; end_y <= ey; end_z <= ez;
        do @(posedge clk); while (!in_ready);
        if (act == ACT_WRITE) begin
            hull_nx[slot] = nx; hull_ny[slot] = ny; hull_nz[slot] = nz; hull_d[slot] = d;
        end else
            pending_hits.push_back(predict_clip(sx, sy, sz, ex, ey, ez));
        if ($urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            @(posedge clk);
            idle_gap();
        end
    endtask

    task automatic write_plane(int slot, logic signed [15:0] nx, ny, nz,
                               logic signed [31:0] d);
        send_beat(ACT_WRITE, 4'(slot), nx, ny, nz, d, '0, '0, '0, '0, '0, '0);
    endtask

    task automatic trace(logic signed [31:0] sx, sy, sz, ex, ey, ez);
        // Noise in the unused plane fields must not matter.
        send_beat(ACT_TRACE, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  $urandom, sx, sy, sz, ex, ey, ez);
    endtask

    // Drain, then wait out any in-flight work before touching registers.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    // Drop any held beat first so the block sees no repeated item.
    task automatic set_reg(logic idx, logic [16:0] val);
        in_valid <= 1'b0;
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_SIDE_COUNT) sides_now = val[4:0];
        else eps_now = val;
    endtask

    // Axis-aligned box of half size h (Q16.16) centered at origin, planes 0..5.
    task automatic load_box(int h);
        write_plane(0, 16384, 0, 0, -h);
        write_plane(1, -16384, 0, 0, -h);
        write_plane(2, 0, 16384, 0, -h);
        write_plane(3, 0, -16384, 0, -h);
        write_plane(4, 0, 0, 16384, -h);
        write_plane(5, 0, 0, -16384, -h);
    endtask

    function automatic logic signed [31:0] rcoord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
        endcase
    endfunction

    function automatic logic signed [15:0] rnorm();
        case ($urandom_range(0, 2))
            0: return $urandom;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // Extremes of every field, box hits and misses, early exit.
    task automatic test_directed();
        for (int i = 0; i < MAX_SIDES; i++)
            write_plane(i, 16'sh7fff, 16'sh8000, 0, 32'sh80000000);
        load_box(10 << 16);
        set_reg(CFG_SIDE_COUNT, 6);
        trace(-(30 << 16), 0, 0, 30 << 16, 0, 0);           // crosses box
        trace(0, 0, 0, 5 << 16, 1 << 16, 0);                // start inside
        trace(20 << 16, 20 << 16, 0, 30 << 16, 25 << 16, 0); // both outside one plane
        trace(0, -(30 << 16), 0, 0, -(5 << 16), 0);          // stops inside
        trace(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
              32'sh80000000, 32'sh80000000, 32'sh80000000);
        trace(32'sh80000000, 0, 32'sh7fffffff, 32'sh7fffffff, -1, 32'sh80000000);
        trace(5, 5, 5, 5, 5, 5);
        write_plane(15, 16'sh8000, 16'sh7fff, 16'sh8000, 32'sh7fffffff);
        trace(1 << 16, 2 << 16, 3 << 16, -(1 << 16), -(2 << 16), -(3 << 16));
        settle();
        set_reg(CFG_SIDE_COUNT, 0);                          // empty hull
        trace(1, 2, 3, 4, 5, 6);
        settle();
        set_reg(CFG_EPSILON, 17'd0);
        set_reg(CFG_SIDE_COUNT, 6);
        trace(-(30 << 16), 1 << 16, 0, 30 << 16, 1 << 16, 0);
        settle();
        set_reg(CFG_EPSILON, 17'h1ffff);                     // above one, used as given
        set_reg(CFG_SIDE_COUNT, 31);                         // clamps to full table
        trace(-(30 << 16), 0, 2 << 16, 30 << 16, 0, 2 << 16);
        trace(0, 0, -(40 << 16), 0, 0, 40 << 16);
        settle();
        set_reg(CFG_EPSILON, 17'd65536);
        set_reg(CFG_SIDE_COUNT, 16);
        trace(0, 0, -(40 << 16), 0, 0, 40 << 16);
        settle();
    endtask

    // Random hulls and segments, well-formed mostly, random noise the rest.
    task automatic test_random(int traces);
        int nplanes;
        for (int i = 0; i < traces; i++) begin
            if (i % 100 == 0) begin
                settle();
                nplanes = (i % 300 == 0) ? 16 : $urandom_range(1, 8);
                set_reg(CFG_SIDE_COUNT, nplanes);
                set_reg(CFG_EPSILON, $urandom_range(0, 3) == 0 ? 17'($urandom)
                                                               : 17'($urandom_range(0, 4096)));
                if ($urandom_range(0, 1)) begin
                    load_box($urandom_range(1, 30) << 16);
                    for (int s = 6; s < MAX_SIDES; s++)
                        write_plane(s, rnorm(), rnorm(), rnorm(), rcoord());
                end else
                    for (int s = 0; s < MAX_SIDES; s++)
                        write_plane(s, rnorm(), rnorm(), rnorm(), rcoord());
            end
            if ($urandom_range(0, 15) == 0)
                write_plane($urandom_range(0, 15), rnorm(), rnorm(), rnorm(), rcoord());
            trace(rcoord(), rcoord(), rcoord(), rcoord(), rcoord(), rcoord());
        end
    endtask

    // Receiver holds off for a long stretch; sender keeps going so the block backs up.
    task automatic test_backpressure();
        rx_hold = 1'b1;
        for (int i = 0; i < 6; i++)
            trace(-(30 << 16), i << 16, 0, 30 << 16, 0, 0);
        wait (!rx_hold);
        settle();
    endtask

    // Receiver: random ready, with a long counted hold-off when asked.
    initial begin
        forever begin
            @(posedge clk);
            if (rx_hold) begin
                out_ready <= 1'b0;
                repeat (3000) @(posedge clk);
                rx_hold = 1'b0;
            end else if (!rx_stall_mode || $urandom_range(0, 3) != 0)
                out_ready <= 1'b1;
            else begin
                out_ready <= 1'b0;
                idle_gap();
            end
        end
    end

    // Check each result beat against the oldest prediction.
    always @(posedge clk) begin
        clip_res_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_hits.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                want = pending_hits.pop_front();
                if (hit !== want.hit) begin
                    $error("hit exp %0d got %0d", want.hit, hit); errors++;
                end
                if (point_x !== want.px) begin
                    $error("point_x exp %0d got %0d", want.px, point_x); errors++;
                end
                if (point_y !== want.py) begin
                    $error("point_y exp %0d got %0d", want.py, point_y); errors++;
                end
                if (point_z !== want.pz) begin
                    $error("point_z exp %0d got %0d", want.pz, point_z); errors++;
                end
                if (normal_valid !== want.nvalid) begin
                    $error("normal_valid exp %0d got %0d", want.nvalid, normal_valid);
                    errors++;
                end
                if (hit_normal_x !== want.nx) begin
                    $error("hit_normal_x exp %0d got %0d", want.nx, hit_normal_x); errors++;
                end
                if (hit_normal_y !== want.ny) begin
                    $error("hit_normal_y exp %0d got %0d", want.ny, hit_normal_y); errors++;
                end
                if (hit_normal_z !== want.nz) begin
                    $error("hit_normal_z exp %0d got %0d", want.nz, hit_normal_z); errors++;
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        rx_stall_mode = 1'b0;
        test_random(150);       // stretch with no receiver idling
        rx_stall_mode = 1'b1;
        test_random(850);
        settle();
        if (pending_hits.size() == 0 && errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Run-time limit.
    initial begin
        #10000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
